[rtl/core/tsw_pkg.sv]
// ----------------------------------------------------------------------------
// Text search package
// Shared command codes, register indexes, character constants, interface
// structs and byte helper functions for the text search block.
// ----------------------------------------------------------------------------
package tsw_pkg;

  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 5;
  localparam int BYTE_W    = 8;
  localparam int OPT_W     = 3;
  localparam int LEN_REG_W = 6;
  localparam int POS_OUT_W = 16;
  localparam int CFG_IDX_W = 1;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [POS_OUT_W-1:0] position_t;

  localparam cmd_t CMD_PATTERN = 2'd0;
  localparam cmd_t CMD_TEXT    = 2'd1;
  localparam cmd_t CMD_END     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OPTIONS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 1'd1;

  localparam int OPT_CASE = 0;
  localparam int OPT_WORD = 1;
  localparam int OPT_LIKE = 2;

  localparam byte_t CHAR_ANY_RUN = 8'h25;
  localparam byte_t CHAR_ANY_ONE = 8'h5F;

  typedef struct packed {
    logic              write;
    logic              text;
    logic              finish;
    logic [SLOT_W-1:0] slot;
    byte_t             data;
  } op_t;

  typedef struct packed {
    logic      found;
    position_t first_position;
    logic      too_long;
  } result_t;

  function automatic byte_t fold(input byte_t c, input logic case_sensitive);
    if (!case_sensitive && c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic logic is_word(input byte_t c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == CHAR_ANY_ONE);
  endfunction

endpackage

[rtl/core/text_search_like_and_word_match.sv]
// ----------------------------------------------------------------------------
// Text search: LIKE wildcard match and substring search
// Input word register, search engine and result register with handshakes on
// both sides, plus the two configuration registers.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake             Payload
//   input    in         in_valid / in_ready   command, pattern_slot, data_byte
//   result   out        out_valid / out_ready found, first_position, too_long
//   config   in         cfg_write             cfg_index, cfg_data
//
// One word per cycle is sustained unless an end-of-text word stalls; a word
// is held in the input register before the engine updates all pattern
// positions at once. An end-of-text word then loads the result register.
// If a result waits, the next end-of-text word stalls and the words behind it
// wait; other words pass. Reset clears the search state, the configuration
// registers and both valid flags; pattern bytes are kept until rewritten.
module text_search_like_and_word_match #(
  parameter int PATTERN_MAX   = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tsw_pkg::CMD_W-1:0]         command,
  input  logic [tsw_pkg::SLOT_W-1:0]        pattern_slot,
  input  logic [tsw_pkg::BYTE_W-1:0]        data_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic [tsw_pkg::POS_OUT_W-1:0]     first_position,
  output logic                              too_long,
  input  logic                              cfg_write,
  input  logic [tsw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsw_pkg::LEN_REG_W-1:0]     cfg_data
);

  logic                              in_held;
  tsw_pkg::cmd_t                     cmd_q;
  logic [tsw_pkg::SLOT_W-1:0]        slot_q;
  tsw_pkg::byte_t                    byte_q;
  logic [tsw_pkg::OPT_W-1:0]         options;
  logic [tsw_pkg::LEN_REG_W-1:0]     pattern_length;
  logic                              fire;
  tsw_pkg::op_t                      op;
  tsw_pkg::result_t                  result;

  assign fire     = in_held && ((cmd_q != tsw_pkg::CMD_END) || !out_valid || out_ready);
  assign in_ready = !in_held || fire;

  assign op.write  = fire && (cmd_q == tsw_pkg::CMD_PATTERN);
  assign op.text   = fire && (cmd_q == tsw_pkg::CMD_TEXT);
  assign op.finish = fire && (cmd_q == tsw_pkg::CMD_END);
  assign op.slot   = slot_q;
  assign op.data   = byte_q;

  tsw_engine #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .options        (options),
    .pattern_length (pattern_length),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      options        <= '0;
      pattern_length <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tsw_pkg::REG_OPTIONS: options        <= cfg_data[tsw_pkg::OPT_W-1:0];
        tsw_pkg::REG_LENGTH:  pattern_length <= cfg_data;
        default:              pattern_length <= pattern_length;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q  <= command;
      slot_q <= pattern_slot;
      byte_q <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.finish) begin
      found          <= result.found;
      first_position <= result.first_position;
      too_long       <= result.too_long;
    end
  end

endmodule

[rtl/core/tsw_engine.sv]
// ----------------------------------------------------------------------------
// Text search engine
// Pattern store, bit-parallel LIKE automaton and shift-and substring matcher.
// Each text word updates every pattern position at once.
// ----------------------------------------------------------------------------
module tsw_engine #(
  parameter int PATTERN_MAX   = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tsw_pkg::op_t                   op,
  input  logic [tsw_pkg::OPT_W-1:0]      options,
  input  logic [tsw_pkg::LEN_REG_W-1:0]  pattern_length,
  output tsw_pkg::result_t               result
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam logic [POSITION_BITS-1:0] POS_LIMIT = '1;

  // A run of percent signs lets an active position reach the ones after it.
  // The carries of an add trace exactly that chain.
  function automatic logic [PATTERN_MAX:0] close_run(
    input logic [PATTERN_MAX:0]   act,
    input logic [PATTERN_MAX-1:0] run
  );
    logic [PATTERN_MAX:0] gen;
    logic [PATTERN_MAX:0] prop;
    logic [PATTERN_MAX:0] sum;
    gen  = {1'b0, act[PATTERN_MAX-1:0] & run};
    prop = {1'b0, run};
    sum  = gen + prop;
    return act | (sum ^ gen ^ prop);
  endfunction

  tsw_pkg::byte_t pattern [PATTERN_MAX];

  logic [PATTERN_MAX:0]     like_set;
  logic [PATTERN_MAX-1:0]   prefix_set;
  logic                     prev_boundary;
  logic [POSITION_BITS-1:0] text_pos;
  logic                     match_seen;
  logic [POSITION_BITS-1:0] match_start;
  logic                     pending;
  logic [POSITION_BITS-1:0] pending_start;
  logic                     overflow;

  logic [PATTERN_MAX:0]     like_set_next;
  logic [PATTERN_MAX-1:0]   prefix_set_next;
  logic                     match_seen_next;
  logic [POSITION_BITS-1:0] match_start_next;
  logic                     pending_next;
  logic [POSITION_BITS-1:0] pending_start_next;

  logic                     case_sens;
  logic                     whole;
  logic                     like_mode;
  logic [LEN_W-1:0]         len;
  logic [PATTERN_MAX-1:0]   in_len;
  logic [PATTERN_MAX:0]     at_len;
  logic [PATTERN_MAX-1:0]   run;
  logic [PATTERN_MAX-1:0]   wild_one;
  logic [PATTERN_MAX-1:0]   same;
  tsw_pkg::byte_t           text_f;
  logic [PATTERN_MAX:0]     like_closed;
  logic [PATTERN_MAX:0]     advanced;
  logic                     like_hit;
  logic                     word_c;
  logic                     settle;
  logic                     seen_a;
  logic [POSITION_BITS-1:0] start_a;
  logic [PATTERN_MAX:0]     shifted;
  logic                     cand;
  logic [POSITION_BITS-1:0] len_m1;
  logic [POSITION_BITS-1:0] cand_start;

  assign case_sens = options[tsw_pkg::OPT_CASE];
  assign whole     = options[tsw_pkg::OPT_WORD];
  assign like_mode = options[tsw_pkg::OPT_LIKE];
  assign len = (32'(pattern_length) > 32'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                        : LEN_W'(pattern_length);
  assign text_f = tsw_pkg::fold(op.data, case_sens);

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      in_len[i]   = 32'(i) < 32'(len);
      run[i]      = in_len[i] && (pattern[i] == tsw_pkg::CHAR_ANY_RUN);
      wild_one[i] = pattern[i] == tsw_pkg::CHAR_ANY_ONE;
      same[i]     = text_f == tsw_pkg::fold(pattern[i], case_sens);
    end
    for (int j = 0; j <= PATTERN_MAX; j++) begin
      at_len[j] = 32'(j) == 32'(len);
    end
  end

  assign like_closed = close_run(like_set, run);

  always_comb begin
    advanced[0] = 1'b0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      advanced[i+1] = in_len[i] &&
                      (run[i] ? like_closed[i+1]
                              : (like_closed[i] && (wild_one[i] || same[i])));
    end
  end

  assign like_set_next = close_run(advanced, run);
  assign like_hit      = |(like_closed & at_len);

  assign word_c  = tsw_pkg::is_word(op.data);
  assign settle  = pending && !word_c && !match_seen;
  assign seen_a  = match_seen || settle;
  assign start_a = settle ? pending_start : match_start;
  assign shifted = {prefix_set, (!whole || prev_boundary)};

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      prefix_set_next[k] = in_len[k] ? (shifted[k] && same[k]) : prefix_set[k];
    end
  end

  assign cand       = (|(prefix_set_next & at_len[PATTERN_MAX:1])) && !seen_a;
  assign len_m1     = POSITION_BITS'(len) - POSITION_BITS'(1);
  assign cand_start = (text_pos >= len_m1) ? (text_pos - len_m1) : '0;

  assign match_seen_next    = seen_a || (cand && !whole);
  assign match_start_next   = (cand && !whole) ? cand_start : start_a;
  assign pending_next       = cand && whole;
  assign pending_start_next = (cand && whole) ? cand_start : pending_start;

  always_comb begin
    result.too_long = overflow;
    priority if (like_mode) begin
      result.found          = like_hit;
      result.first_position = '0;
    end else if (len == '0) begin
      result.found          = 1'b1;
      result.first_position = '0;
    end else begin
      result.found = match_seen || pending;
      if (match_seen) begin
        result.first_position = tsw_pkg::position_t'(match_start);
      end else if (pending) begin
        result.first_position = tsw_pkg::position_t'(pending_start);
      end else begin
        result.first_position = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (op.write && (32'(op.slot) == i)) begin
        pattern[i] <= op.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || op.finish) begin
      like_set      <= (PATTERN_MAX + 1)'(1);
      prefix_set    <= '0;
      prev_boundary <= 1'b1;
      text_pos      <= '0;
      match_seen    <= 1'b0;
      match_start   <= '0;
      pending       <= 1'b0;
      pending_start <= '0;
      overflow      <= 1'b0;
    end else if (op.text) begin
      like_set      <= like_set_next;
      prefix_set    <= prefix_set_next;
      prev_boundary <= !word_c;
      match_seen    <= match_seen_next;
      match_start   <= match_start_next;
      pending       <= pending_next;
      pending_start <= pending_start_next;
      if (text_pos == POS_LIMIT) begin
        overflow <= 1'b1;
      end else begin
        text_pos <= text_pos + POSITION_BITS'(1);
      end
    end
  end

endmodule

[rtl/core/tsw_checker.sv]
// ----------------------------------------------------------------------------
// Text search port checker
// Watches the top-level ports of the text search block over time.
// ----------------------------------------------------------------------------
module tsw_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              found,
  input logic [tsw_pkg::POS_OUT_W-1:0]     first_position
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // A miss never reports a start position.
  a_miss_no_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> first_position == '0)
    else $error("miss reported with a nonzero position");

  // Reset leaves no result pending.
  a_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // Reset leaves the input register empty and ready.
  a_reset_in: assert property (@(posedge clk)
    $past(rst) |-> in_ready)
    else $error("input not ready right after reset");

endmodule

bind text_search_like_and_word_match tsw_checker u_tsw_checker (.*);
